// ===== design/ptr_pkg.sv =====
// shared types, constants and helpers for the prescaled timer
package ptr_pkg;

  localparam int unsigned ElapsedW  = 6;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CycleW    = 14;
  localparam int unsigned PrescaleW = 9;
  localparam int unsigned CtrlW     = 3;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [ElapsedW-1:0] MaxElapsed = 6'd63;

  localparam logic CfgIdxControl = 1'b0;
  localparam logic CfgIdxModulo  = 1'b1;

  localparam int unsigned CtrlEnableBit = 2;

  typedef enum logic [1:0] {
    PER_256 = 2'd0,
    PER_4   = 2'd1,
    PER_16  = 2'd2,
    PER_64  = 2'd3
  } period_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_HOLD
  } seq_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } seq_ctrl_t;

  function automatic logic [PrescaleW-1:0] period_of(input period_sel_e sel);
    logic [PrescaleW-1:0] p;
    case (sel)
      PER_256: p = 9'd256;
      PER_4:   p = 9'd4;
      PER_16:  p = 9'd16;
      PER_64:  p = 9'd64;
      default: p = 9'd256;
    endcase
    return p;
  endfunction

endpackage

// ===== design/ptr_seq.sv =====
// sequencer for load, drain and result hand-off
module ptr_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               more_i,
  input  logic               out_free_i,
  output logic               in_ready_o,
  output ptr_pkg::seq_ctrl_t ctrl_o
);
  import ptr_pkg::*;

  seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!more_i) state_d = out_free_i ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    ctrl_o.load     = 1'b0;
    ctrl_o.step     = 1'b0;
    ctrl_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_DRAIN: begin
        ctrl_o.step     = more_i;
        ctrl_o.out_load = !more_i && out_free_i;
      end
      ST_HOLD: begin
        ctrl_o.out_load = out_free_i;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/prescaled_timer_with_reload.sv =====
// prescaled timer top level: divider, prescaler and reloading counter
//
//  channel   direction  signals
//  in        sink       in_valid_i, in_ready_o, elapsed_cycles_i
//  out       source     out_valid_o, out_ready_i, counter_value_o,
//                       divider_value_o, wrap_flag_o
//  cfg       sink       cfg_we_i, cfg_idx_i, cfg_data_i
//
//  a transaction causes n counter increments
//  (0 to 79, one per cycle through the shared compare and subtract unit)
//  reset clears the sequencer, state and output valid; no clearing pass
//  a result waiting on out_ready_i holds the next transaction in the hold state
module prescaled_timer_with_reload (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptr_pkg::ElapsedW-1:0]  elapsed_cycles_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptr_pkg::CountW-1:0]    counter_value_o,
  output logic [ptr_pkg::CountW-1:0]    divider_value_o,
  output logic                          wrap_flag_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ptr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ptr_pkg::*;

  logic [CtrlW-1:0]     control_q;
  logic [CountW-1:0]    modulo_q;
  logic [CycleW-1:0]    cycle_q, cycle_d;
  logic [PrescaleW-1:0] pre_q, pre_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic                 irq_q, irq_d;
  logic                 out_valid_q;
  logic [CountW-1:0]    out_cnt_q, out_div_q;
  logic                 out_irq_q;

  logic [ElapsedW-1:0]  elapsed;
  logic [PrescaleW-1:0] period;
  logic                 enabled;
  logic                 more;
  logic                 out_free;
  logic [CountW-1:0]    cnt_inc;
  seq_ctrl_t            ctrl;

  assign elapsed  = (elapsed_cycles_i > MaxElapsed) ? MaxElapsed : elapsed_cycles_i;
  assign enabled  = control_q[CtrlEnableBit];
  assign period   = period_of(period_sel_e'(control_q[1:0]));
  assign more     = enabled && (pre_q >= period);
  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_inc  = cnt_q + 8'd1;

  ptr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .more_i     (more),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= '0;
      modulo_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxControl: control_q <= cfg_data_i[CtrlW-1:0];
        CfgIdxModulo:  modulo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cycle_d = cycle_q;
    pre_d   = pre_q;
    cnt_d   = cnt_q;
    irq_d   = irq_q;
    if (ctrl.load) begin
      cycle_d = cycle_q + {{(CycleW-ElapsedW){1'b0}}, elapsed};
      irq_d   = 1'b0;
      if (enabled) pre_d = pre_q + {{(PrescaleW-ElapsedW){1'b0}}, elapsed};
    end else if (ctrl.step) begin
      pre_d = pre_q - period;
      irq_d = irq_q;
      if (cnt_inc == '0) begin
        cnt_d = modulo_q;
        irq_d = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= '0;
      pre_q   <= '0;
      cnt_q   <= '0;
      irq_q   <= 1'b0;
    end else begin
      cycle_q <= cycle_d;
      pre_q   <= pre_d;
      cnt_q   <= cnt_d;
      irq_q   <= irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_cnt_q <= cnt_q;
      out_div_q <= cycle_q[CycleW-1:CycleW-CountW];
      out_irq_q <= irq_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign counter_value_o = out_cnt_q;
  assign divider_value_o = out_div_q;
  assign wrap_flag_o     = out_irq_q;

endmodule

// ===== verif/ptr_checker.sv =====
`timescale 1ns / 100ps
// checker for the prescaled timer: tracks config writes, predicts each result and compares it
module ptr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [ptr_pkg::ElapsedW-1:0] elapsed_cycles_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [ptr_pkg::CountW-1:0]   counter_value_i,
  input  logic [ptr_pkg::CountW-1:0]   divider_value_i,
  input  logic                         wrap_flag_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ptr_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           outstanding_o,
  output int                           fail_count_o,
  output int                           checked_o,
  output int                           wraps_o
);
  import ptr_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] counter;
    logic [CountW-1:0] divider;
    logic              irq;
  } timer_result_t;

  timer_result_t        expected_q[$];
  logic [CtrlW-1:0]     control;
  logic [CountW-1:0]    modulo;
  logic [CycleW-1:0]    cycle_total;
  logic [PrescaleW-1:0] prescale;
  logic [CountW-1:0]    tick_count;

  function automatic int unsigned period_cycles(period_sel_e sel);
    case (sel)
      PER_4:   return 4;
      PER_16:  return 16;
      PER_64:  return 64;
      default: return 256;
    endcase
  endfunction

  function automatic timer_result_t advance_timer(logic [ElapsedW-1:0] elapsed);
    int unsigned   acc;
    int unsigned   period;
    timer_result_t res;
    res.irq = 1'b0;
    cycle_total = cycle_total + elapsed;
    if (control[CtrlEnableBit]) begin
      period = period_cycles(period_sel_e'(control[1:0]));
      acc = prescale + elapsed;
      while (acc >= period) begin
        acc -= period;
        tick_count = tick_count + 1'b1;
        if (tick_count == '0) begin
          tick_count = modulo;
          res.irq = 1'b1;
        end
      end
      prescale = PrescaleW'(acc);
    end
    res.counter = tick_count;
    res.divider = cycle_total[CycleW-1:6];
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      control = '0;
      modulo = '0;
      cycle_total = '0;
      prescale = '0;
      tick_count = '0;
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxControl) begin
          control = cfg_data_i[CtrlW-1:0];
        end else begin
          modulo = cfg_data_i[CountW-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{counter_value_i, divider_value_i, wrap_flag_i};
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result with none pending: counter %0d divider %0d irq %0d",
                                 got.counter, got.divider, got.irq));
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (want.irq) begin
            wraps_o++;
          end
          if (got.counter !== want.counter) begin
            note_failure($sformatf("counter_value expected %0d, got %0d",
                                   want.counter, got.counter));
          end
          if (got.divider !== want.divider) begin
            note_failure($sformatf("divider_value expected %0d, got %0d",
                                   want.divider, got.divider));
          end
          if (got.irq !== want.irq) begin
            note_failure($sformatf("wrap_flag expected %0d, got %0d",
                                   want.irq, got.irq));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(advance_timer(elapsed_cycles_i));
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the prescaled timer: stimulus, config phases, watchdog and verdict
module tb;
  import ptr_pkg::*;

  localparam int StallLimit = 3000;
  localparam int ItemTarget = 1025;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ElapsedW-1:0] elapsed = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [CountW-1:0]   counter_value;
  logic [CountW-1:0]   divider_value;
  logic                timer_irq;
  logic                cfg_we = 1'b0;
  logic                cfg_idx = CfgIdxControl;
  logic [CfgDataW-1:0] cfg_data = '0;

  int outstanding;
  int fail_count;
  int checked;
  int wraps;
  int items_sent = 0;
  int phases = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  prescaled_timer_with_reload DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .elapsed_cycles_i (elapsed),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .counter_value_o  (counter_value),
    .divider_value_o  (divider_value),
    .wrap_flag_o      (timer_irq),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  ptr_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .elapsed_cycles_i (elapsed),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .counter_value_i  (counter_value),
    .divider_value_i  (divider_value),
    .wrap_flag_i      (timer_irq),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .outstanding_o    (outstanding),
    .fail_count_o     (fail_count),
    .checked_o        (checked),
    .wraps_o          (wraps)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ElapsedW-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return MaxElapsed;
    if (r < 15) return '0;
    return ElapsedW'($urandom_range(0, 63));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_modulo();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 60) return CfgDataW'($urandom_range(8'hF0, 8'hFF));
    return CfgDataW'($urandom_range(0, 255));
  endfunction

  // sink side: random stall bursts, none in quiet phases
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("no transaction for %0d cycles", StallLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_elapsed(logic [ElapsedW-1:0] value);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    elapsed <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // drain the block, then write registers while it is idle
  task automatic configure(bit wr_ctrl, logic [CfgDataW-1:0] ctrl_data,
                           bit wr_mod, logic [CfgDataW-1:0] mod_data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (wr_ctrl) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxControl;
      cfg_data <= ctrl_data;
      @(posedge clk);
    end
    if (wr_mod) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxModulo;
      cfg_data <= mod_data;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    quiet = ($urandom_range(0, 4) == 0);
    stall_pct = quiet ? 0 : $urandom_range(5, 40);
    phases++;
  endtask

  initial begin
    logic [CfgDataW-1:0] ctrl_data;
    logic [CfgDataW-1:0] mod_data;
    bit                  wr_ctrl;
    bit                  wr_mod;
    int                  burst;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // timer off, divider only
    configure(1'b1, 8'h00, 1'b1, 8'h00);
    send_elapsed('0);
    send_elapsed(MaxElapsed);
    // slowest period builds up the prescaler
    configure(1'b1, 8'h04, 1'b1, 8'hFF);
    repeat (4) send_elapsed(MaxElapsed);
    // disabled with junk upper bits: prescaler held
    configure(1'b1, 8'hFB, 1'b0, '0);
    send_elapsed(MaxElapsed);
    // switch to a shorter period drains the held count
    configure(1'b1, 8'h07, 1'b0, '0);
    send_elapsed(MaxElapsed);
    // fastest period until the counter wraps, then repeated wraps per step
    configure(1'b1, 8'h05, 1'b1, 8'hFE);
    repeat (16) send_elapsed(MaxElapsed);

    while (items_sent < ItemTarget) begin
      wr_ctrl = ($urandom_range(0, 5) != 0);
      wr_mod = ($urandom_range(0, 2) != 0);
      if (!wr_ctrl && !wr_mod) begin
        wr_mod = 1'b1;
      end
      ctrl_data = CfgDataW'($urandom());
      if ($urandom_range(0, 3) != 0) begin
        ctrl_data[CtrlEnableBit] = 1'b1;
      end
      mod_data = pick_modulo();
      configure(wr_ctrl, ctrl_data, wr_mod, mod_data);
      burst = $urandom_range(20, 80);
      repeat (burst) send_elapsed(pick_elapsed());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d elapsed-cycle transactions across %0d register settings",
             items_sent, phases);
    $display("checked %0d results, %0d of them flagged a counter wrap", checked, wraps);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
